// File: design/eight_bit_cpu_alu_with_flags_core_macros.svh
// Assertion macros for the 8-bit ALU core checker.
// Included by the checker file; needs clk and rst_n in scope.
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_CORE_MACROS_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_CORE_MACROS_SVH

// Check a property outside reset.
`define CPUALU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("alu check failed");

// Check a property that also covers the reset cycles.
`define CPUALU_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("alu reset check failed");

`endif

// File: design/cpualu_pkg.sv
// Shared types and constants for the 8-bit ALU core.
// No dependencies; imported by every module of the core.
package cpualu_pkg;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_CP    = 5'd4,
    OP_AND   = 5'd5,
    OP_XOR   = 5'd6,
    OP_OR    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_RLC   = 5'd10,
    OP_RRC   = 5'd11,
    OP_RL    = 5'd12,
    OP_RR    = 5'd13,
    OP_SLA   = 5'd14,
    OP_SRA   = 5'd15,
    OP_SWAP  = 5'd16,
    OP_SRL   = 5'd17,
    OP_BIT   = 5'd18,
    OP_RES   = 5'd19,
    OP_SET   = 5'd20,
    OP_DAA   = 5'd21,
    OP_CPL   = 5'd22,
    OP_SCF   = 5'd23,
    OP_CCF   = 5'd24,
    OP_ADD16 = 5'd25,
    OP_INC16 = 5'd26,
    OP_DEC16 = 5'd27
  } op_t;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [7:0] DAA_LIMIT = 8'h99;
  localparam logic [7:0] DAA_HI    = 8'h60;
  localparam logic [7:0] DAA_LO    = 8'h06;
  localparam logic [3:0] BCD_MAX   = 4'h9;

  typedef struct packed {
    op_t         op;
    logic        c;
    logic        h;
    logic        n;
    logic        z;
    logic [2:0]  bit_idx;
    logic [15:0] b;
    logic [15:0] a;
  } req_t;

  typedef struct packed {
    logic        c;
    logic        h;
    logic        n;
    logic        z;
    logic        wb;
    logic [15:0] value;
  } res_t;

endpackage

// File: design/eight_bit_cpu_alu_with_flags_core.sv
// Path: input register, combinational ALU datapath, result register; out_tvalid comes from the result register.
// Throughput: one request per cycle while out_tready is high; the ALU datapath sits between two registers.
// Stalls: out_tready low holds the result; in_tready drops only when both regs are full and out_tready is low.
// Reset: synchronous active-low rst_n clears both valid bits and drops any request in flight.
// Top level of the 8-bit ALU core; depends on cpualu_pkg and the cpualu_* stages.
module eight_bit_cpu_alu_with_flags_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // req_type
  input  logic [4:0]                          in_tuser,
  // operand_a, operand_b, bit_index, zero_in, subtract_in, half_carry_in,
  // carry_in, zero pad
  input  logic [cpualu_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // result_value, write_back, zero_out, subtract_out, half_carry_out,
  // carry_out, zero pad
  output logic [cpualu_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import cpualu_pkg::*;

  logic take;
  logic s1_vld;
  req_t s1_req;
  res_t s1_res;

  cpualu_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .take      (take),
    .vld       (s1_vld),
    .req       (s1_req)
  );

  cpualu_exec u_exec (
    .req (s1_req),
    .res (s1_res)
  );

  cpualu_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld        (s1_vld),
    .res        (s1_res),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: design/cpualu_in_stage.sv
// Input register of the ALU core: captures one request per cycle while it is empty or its request is taken.
// Depends on cpualu_pkg.
module cpualu_in_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [4:0]                          in_tuser,
  input  logic [cpualu_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                                take,
  output logic                                vld,
  output cpualu_pkg::req_t                    req
);
  import cpualu_pkg::*;

  logic vld_r;
  logic vld_nxt;
  req_t req_r;
  logic acc;

  assign in_tready = !vld_r || take;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (acc) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      req_r.op      <= op_t'(in_tuser);
      req_r.a       <= in_tdata[15:0];
      req_r.b       <= in_tdata[31:16];
      req_r.bit_idx <= in_tdata[34:32];
      req_r.z       <= in_tdata[35];
      req_r.n       <= in_tdata[36];
      req_r.h       <= in_tdata[37];
      req_r.c       <= in_tdata[38];
    end
  end

  assign vld = vld_r;
  assign req = req_r;

endmodule

// File: design/cpualu_exec.sv
// Combinational ALU datapath: value, write-back mark and flags per request.
// Depends on cpualu_pkg.
module cpualu_exec (
  input  cpualu_pkg::req_t req,
  output cpualu_pkg::res_t res
);
  import cpualu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  hsum;
  logic [8:0]  dif9;
  logic [4:0]  hdif;
  logic [7:0]  mask;
  logic [7:0]  r8;
  logic [7:0]  daa_r;
  logic        daa_c;
  logic [16:0] sum17;
  logic [12:0] hsum13;

  assign a      = req.a[7:0];
  assign b      = req.b[7:0];
  assign cin    = ((req.op == OP_ADC) || (req.op == OP_SBC)) && req.c;
  assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, cin};
  assign hsum   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
  assign dif9   = {1'b0, a} - {1'b0, b} - {8'd0, cin};
  assign hdif   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
  assign mask   = 8'd1 << req.bit_idx;
  assign sum17  = {1'b0, req.a} + {1'b0, req.b};
  assign hsum13 = {1'b0, req.a[11:0]} + {1'b0, req.b[11:0]};

  always_comb begin
    daa_r = a;
    daa_c = req.c;
    if (req.n) begin
      if (req.c) begin
        daa_r = daa_r - DAA_HI;
      end
      if (req.h) begin
        daa_r = daa_r - DAA_LO;
      end
    end else begin
      if (req.c || (a > DAA_LIMIT)) begin
        daa_r = daa_r + DAA_HI;
        daa_c = 1'b1;
      end
      if (req.h || (a[3:0] > BCD_MAX)) begin
        daa_r = daa_r + DAA_LO;
      end
    end
  end

  always_comb begin
    r8        = 8'd0;
    res.value = 16'd0;
    res.wb    = 1'b1;
    res.z     = req.z;
    res.n     = 1'b0;
    res.h     = 1'b0;
    res.c     = req.c;
    case (req.op)
      OP_ADD, OP_ADC: begin
        r8    = sum9[7:0];
        res.h = hsum[4];
        res.c = sum9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r8    = dif9[7:0];
        res.n = 1'b1;
        res.h = hdif[4];
        res.c = dif9[8];
      end
      OP_AND: begin
        r8    = a & b;
        res.h = 1'b1;
        res.c = 1'b0;
      end
      OP_XOR: begin
        r8    = a ^ b;
        res.c = 1'b0;
      end
      OP_OR: begin
        r8    = a | b;
        res.c = 1'b0;
      end
      OP_INC: begin
        r8    = a + 8'd1;
        res.h = (a[3:0] == 4'hF);
      end
      OP_DEC: begin
        r8    = a - 8'd1;
        res.n = 1'b1;
        res.h = (a[3:0] == 4'h0);
      end
      OP_RLC: begin
        r8    = {a[6:0], a[7]};
        res.c = a[7];
      end
      OP_RRC: begin
        r8    = {a[0], a[7:1]};
        res.c = a[0];
      end
      OP_RL: begin
        r8    = {a[6:0], req.c};
        res.c = a[7];
      end
      OP_RR: begin
        r8    = {req.c, a[7:1]};
        res.c = a[0];
      end
      OP_SLA: begin
        r8    = {a[6:0], 1'b0};
        res.c = a[7];
      end
      OP_SRA: begin
        r8    = {a[7], a[7:1]};
        res.c = a[0];
      end
      OP_SWAP: begin
        r8    = {a[3:0], a[7:4]};
        res.c = 1'b0;
      end
      OP_SRL: begin
        r8    = {1'b0, a[7:1]};
        res.c = a[0];
      end
      OP_BIT: begin
        res.h = 1'b1;
      end
      OP_RES: begin
        r8    = a & ~mask;
        res.n = req.n;
        res.h = req.h;
      end
      OP_SET: begin
        r8    = a | mask;
        res.n = req.n;
        res.h = req.h;
      end
      OP_DAA: begin
        r8    = daa_r;
        res.n = req.n;
        res.c = daa_c;
      end
      OP_CPL: begin
        r8    = ~a;
        res.n = 1'b1;
        res.h = 1'b1;
      end
      OP_SCF: begin
        res.c = 1'b1;
      end
      OP_CCF: begin
        res.c = ~req.c;
      end
      OP_ADD16: begin
        res.h = hsum13[12];
        res.c = sum17[16];
      end
      OP_INC16, OP_DEC16: begin
        res.n = req.n;
        res.h = req.h;
      end
      default: begin
        res.n = req.n;
        res.h = req.h;
      end
    endcase

    case (req.op)
      OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CP, OP_AND, OP_XOR, OP_OR, OP_INC, OP_DEC,
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL, OP_DAA: begin
        res.z = (r8 == 8'd0);
      end
      OP_BIT: begin
        res.z = ((a & mask) == 8'd0);
      end
      default: begin
        res.z = req.z;
      end
    endcase

    case (req.op)
      OP_CP, OP_BIT, OP_SCF, OP_CCF: begin
        res.wb    = 1'b0;
        res.value = 16'd0;
      end
      OP_ADD16: begin
        res.value = sum17[15:0];
      end
      OP_INC16: begin
        res.value = req.a + 16'd1;
      end
      OP_DEC16: begin
        res.value = req.a - 16'd1;
      end
      OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_AND, OP_XOR, OP_OR, OP_INC, OP_DEC,
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL,
      OP_RES, OP_SET, OP_DAA, OP_CPL: begin
        res.value = {8'd0, r8};
      end
      default: begin
        res.wb    = 1'b0;
        res.value = 16'd0;
      end
    endcase
  end

endmodule

// File: design/cpualu_out_stage.sv
// Result register of the ALU core: holds a result until the sink takes it.
// Depends on cpualu_pkg.
module cpualu_out_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                vld,
  input  cpualu_pkg::res_t                    res,
  output logic                                take,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cpualu_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import cpualu_pkg::*;

  logic vld_r;
  logic vld_nxt;
  res_t res_r;

  assign take    = !vld_r || out_tready;
  assign vld_nxt = take ? vld : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && vld) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {3'd0, res_r};

endmodule

// File: design/cpualu_checker.sv
// Port-level checks for the 8-bit ALU core, bound to the top level.
// Depends on eight_bit_cpu_alu_with_flags_core_macros.svh.
`include "eight_bit_cpu_alu_with_flags_core_macros.svh"

module cpualu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  `CPUALU_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid)
  `CPUALU_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `CPUALU_ASSERT(a_nowb_zero, out_tvalid && !out_tdata[16] |-> out_tdata[15:0] == 16'd0)
  `CPUALU_ASSERT(a_ready_empty, !out_tvalid |-> in_tready)
  `CPUALU_ASSERT(a_byte_pad, out_tvalid |-> out_tdata[23:21] == 3'd0)

endmodule

bind eight_bit_cpu_alu_with_flags_core cpualu_checker u_cpualu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/tb_eight_bit_cpu_alu_with_flags_core.sv
// Self-checking testbench for eight_bit_cpu_alu_with_flags_core: directed and random
// ALU requests with random stalls on both stream ports, checked against a local predictor.
// Depends on cpualu_pkg and the core RTL.
module tb_eight_bit_cpu_alu_with_flags_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cpualu_pkg::*;

  localparam logic [4:0] OP_UNUSED_FIRST = 5'd28;
  localparam logic [4:0] OP_UNUSED_LAST  = 5'd31;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int QUIET_TAIL      = 200;
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef struct packed {
    logic [4:0]  op;
    logic        c;
    logic        h;
    logic        n;
    logic        z;
    logic [2:0]  bidx;
    logic [15:0] b;
    logic [15:0] a;
  } alu_req_s;

  typedef struct {
    alu_req_s req;
    bit       settle;
  } pending_req_s;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [4:0]            in_tuser = '0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  pending_req_s alu_requests[$];
  res_t         expected_results[$];
  alu_req_s     on_bus;
  pending_req_s next_req;
  int           driven = 0;
  int           send_gap = 0;
  int           recv_stall = 0;
  int           total_requests = 0;
  int           accepted = 0;
  int           quiet_cycles = 0;
  int           mismatches = 0;

  eight_bit_cpu_alu_with_flags_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic res_t compute_alu_result(input alu_req_s q);
    logic [7:0]  a8;
    logic [7:0]  r8;
    logic [8:0]  wide9;
    logic [4:0]  nib;
    logic [12:0] low13;
    logic [16:0] sum17;
    logic        cin;
    res_t        y;
    a8 = q.a[7:0];
    y.value = '0;
    y.wb = 1'b1;
    y.z = q.z;
    y.n = q.n;
    y.h = q.h;
    y.c = q.c;
    case (q.op)
      OP_ADD, OP_ADC: begin
        cin = (q.op == OP_ADC) ? q.c : 1'b0;
        wide9 = {1'b0, a8} + {1'b0, q.b[7:0]} + {8'h00, cin};
        nib = {1'b0, a8[3:0]} + {1'b0, q.b[3:0]} + {4'h0, cin};
        y.value = {8'h00, wide9[7:0]};
        y.z = (wide9[7:0] == 8'h00);
        y.n = 1'b0;
        y.h = nib[4];
        y.c = wide9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        cin = (q.op == OP_SBC) ? q.c : 1'b0;
        wide9 = {1'b0, a8} - {1'b0, q.b[7:0]} - {8'h00, cin};
        nib = {1'b0, a8[3:0]} - {1'b0, q.b[3:0]} - {4'h0, cin};
        y.value = (q.op == OP_CP) ? 16'h0000 : {8'h00, wide9[7:0]};
        y.wb = (q.op != OP_CP);
        y.z = (wide9[7:0] == 8'h00);
        y.n = 1'b1;
        y.h = nib[4];
        y.c = wide9[8];
      end
      OP_AND, OP_XOR, OP_OR: begin
        if (q.op == OP_AND) r8 = a8 & q.b[7:0];
        else if (q.op == OP_XOR) r8 = a8 ^ q.b[7:0];
        else r8 = a8 | q.b[7:0];
        y.value = {8'h00, r8};
        y.z = (r8 == 8'h00);
        y.n = 1'b0;
        y.h = (q.op == OP_AND);
        y.c = 1'b0;
      end
      OP_INC, OP_DEC: begin
        r8 = (q.op == OP_INC) ? a8 + 8'h01 : a8 - 8'h01;
        y.value = {8'h00, r8};
        y.z = (r8 == 8'h00);
        y.n = (q.op == OP_DEC);
        y.h = (q.op == OP_INC) ? (a8[3:0] == 4'hF) : (a8[3:0] == 4'h0);
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        case (q.op)
          OP_RLC: begin
            r8 = {a8[6:0], a8[7]};
            y.c = a8[7];
          end
          OP_RRC: begin
            r8 = {a8[0], a8[7:1]};
            y.c = a8[0];
          end
          OP_RL: begin
            r8 = {a8[6:0], q.c};
            y.c = a8[7];
          end
          OP_RR: begin
            r8 = {q.c, a8[7:1]};
            y.c = a8[0];
          end
          OP_SLA: begin
            r8 = {a8[6:0], 1'b0};
            y.c = a8[7];
          end
          OP_SRA: begin
            r8 = {a8[7], a8[7:1]};
            y.c = a8[0];
          end
          OP_SWAP: begin
            r8 = {a8[3:0], a8[7:4]};
            y.c = 1'b0;
          end
          default: begin
            r8 = {1'b0, a8[7:1]};
            y.c = a8[0];
          end
        endcase
        y.value = {8'h00, r8};
        y.z = (r8 == 8'h00);
        y.n = 1'b0;
        y.h = 1'b0;
      end
      OP_BIT: begin
        y.wb = 1'b0;
        y.z = ~a8[q.bidx];
        y.n = 1'b0;
        y.h = 1'b1;
      end
      OP_RES: y.value = {8'h00, a8 & ~(8'h01 << q.bidx)};
      OP_SET: y.value = {8'h00, a8 | (8'h01 << q.bidx)};
      OP_DAA: begin
        r8 = a8;
        if (q.n) begin
          if (q.c) r8 = r8 - DAA_HI;
          if (q.h) r8 = r8 - DAA_LO;
        end else begin
          if (q.c || a8 > DAA_LIMIT) begin
            r8 = r8 + DAA_HI;
            y.c = 1'b1;
          end
          if (q.h || a8[3:0] > BCD_MAX) r8 = r8 + DAA_LO;
        end
        y.value = {8'h00, r8};
        y.z = (r8 == 8'h00);
        y.h = 1'b0;
      end
      OP_CPL: begin
        y.value = {8'h00, ~a8};
        y.n = 1'b1;
        y.h = 1'b1;
      end
      OP_SCF, OP_CCF: begin
        y.wb = 1'b0;
        y.n = 1'b0;
        y.h = 1'b0;
        y.c = (q.op == OP_SCF) ? 1'b1 : ~q.c;
      end
      OP_ADD16: begin
        sum17 = {1'b0, q.a} + {1'b0, q.b};
        low13 = {1'b0, q.a[11:0]} + {1'b0, q.b[11:0]};
        y.value = sum17[15:0];
        y.n = 1'b0;
        y.h = low13[12];
        y.c = sum17[16];
      end
      OP_INC16: y.value = q.a + 16'h0001;
      OP_DEC16: y.value = q.a - 16'h0001;
      default: y.wb = 1'b0;
    endcase
    return y;
  endfunction

  task automatic queue_request(input logic [4:0] op, input logic [15:0] a, input logic [15:0] b,
                               input logic [2:0] bidx, input logic [3:0] znhc,
                               input bit settle = 1'b0);
    pending_req_s p;
    p.req.op = op;
    p.req.a = a;
    p.req.b = b;
    p.req.bidx = bidx;
    {p.req.z, p.req.n, p.req.h, p.req.c} = znhc;
    p.settle = settle;
    alu_requests.push_back(p);
    total_requests++;
  endtask

  function automatic logic [15:0] pick_operand();
    logic [15:0] v;
    v = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 6))
        0: v[7:0] = 8'h00;
        1: v[7:0] = 8'hFF;
        2: v[7:0] = 8'h0F;
        3: v[7:0] = 8'h99;
        4: v[7:0] = 8'h9A;
        5: v = 16'h0FFF;
        default: v = 16'hFFFF;
      endcase
    end
    return v;
  endfunction

  task automatic check_result(input res_t got);
    res_t want;
    if (expected_results.size() == 0) begin
      $error("result %h arrived with no request outstanding", got);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    if (got.value !== want.value) begin
      $error("result_value: expected %h, got %h", want.value, got.value);
      mismatches++;
    end
    if (got.wb !== want.wb) begin
      $error("write_back: expected %b, got %b", want.wb, got.wb);
      mismatches++;
    end
    if (got.z !== want.z) begin
      $error("zero_out: expected %b, got %b", want.z, got.z);
      mismatches++;
    end
    if (got.n !== want.n) begin
      $error("subtract_out: expected %b, got %b", want.n, got.n);
      mismatches++;
    end
    if (got.h !== want.h) begin
      $error("half_carry_out: expected %b, got %b", want.h, got.h);
      mismatches++;
    end
    if (got.c !== want.c) begin
      $error("carry_out: expected %b, got %b", want.c, got.c);
      mismatches++;
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && accepted != driven) begin
      // hold the request until it is accepted
    end else begin
      if (send_gap != 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (alu_requests.size() == 0 ||
                   (alu_requests[0].settle && expected_results.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else begin
        next_req = alu_requests.pop_front();
        on_bus = next_req.req;
        in_tuser <= on_bus.op;
        in_tdata <= {1'b0, on_bus[38:0]};
        in_tvalid <= 1'b1;
        driven++;
        if (alu_requests.size() > QUIET_TAIL && $urandom_range(0, 11) == 0)
          send_gap = $urandom_range(1, 18);
      end
    end
  end

  // result receiver backpressure
  always @(negedge clk) begin
    if (recv_stall != 0) begin
      recv_stall--;
      out_tready <= 1'b0;
    end else if (rst_n && alu_requests.size() > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
      recv_stall = $urandom_range(0, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // accept, check and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (in_tvalid && in_tready) begin
        expected_results.push_back(compute_alu_result(on_bus));
        accepted++;
        quiet_cycles = 0;
      end
      if (out_tvalid && out_tready) begin
        check_result(res_t'(out_tdata[20:0]));
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [4:0]  op;
    logic [15:0] a;
    logic [15:0] b;
    logic [3:0]  flags;
    res_t        sum;
    alu_req_s    probe;

    queue_request(OP_ADD,   16'hAB80, 16'h5480, 3'd0, 4'b1011);
    queue_request(OP_ADC,   16'h000F, 16'h0000, 3'd0, 4'b0001);
    queue_request(OP_ADC,   16'h00FF, 16'hFF00, 3'd0, 4'b0001);
    queue_request(OP_SUB,   16'h0000, 16'h0001, 3'd0, 4'b1000);
    queue_request(OP_SBC,   16'h0010, 16'h000F, 3'd0, 4'b0001);
    queue_request(OP_CP,    16'h1242, 16'h3442, 3'd0, 4'b0000);
    queue_request(OP_AND,   16'hFFF0, 16'hFF0F, 3'd0, 4'b0001);
    queue_request(OP_XOR,   16'h00FF, 16'h00FF, 3'd0, 4'b0111);
    queue_request(OP_OR,    16'hFF00, 16'h0000, 3'd0, 4'b0000);
    queue_request(OP_INC,   16'h00FF, 16'h0000, 3'd0, 4'b0001);
    queue_request(OP_DEC,   16'h0010, 16'h0000, 3'd0, 4'b0000);
    queue_request(OP_RLC,   16'h0080, 16'h0000, 3'd0, 4'b0000);
    queue_request(OP_RRC,   16'h0001, 16'h0000, 3'd0, 4'b0000);
    queue_request(OP_RL,    16'h0080, 16'h0000, 3'd0, 4'b0000);
    queue_request(OP_RR,    16'h0001, 16'h0000, 3'd0, 4'b0001);
    queue_request(OP_SLA,   16'h0080, 16'h0000, 3'd0, 4'b0000);
    queue_request(OP_SRA,   16'h0081, 16'h0000, 3'd0, 4'b0000);
    queue_request(OP_SWAP,  16'h00F0, 16'h0000, 3'd0, 4'b0001);
    queue_request(OP_SRL,   16'h0001, 16'h0000, 3'd0, 4'b0000);
    queue_request(OP_BIT,   16'h007F, 16'h0000, 3'd7, 4'b0101);
    queue_request(OP_RES,   16'h00FF, 16'h0000, 3'd0, 4'b1010);
    queue_request(OP_SET,   16'h0000, 16'h0000, 3'd7, 4'b0101);
    queue_request(OP_DAA,   16'h009A, 16'h0000, 3'd0, 4'b0000);
    queue_request(OP_DAA,   16'h0066, 16'h0000, 3'd0, 4'b0111);
    queue_request(OP_CPL,   16'h0000, 16'h0000, 3'd0, 4'b1000);
    queue_request(OP_SCF,   16'h00FF, 16'h0000, 3'd0, 4'b1110);
    queue_request(OP_CCF,   16'h00FF, 16'h0000, 3'd0, 4'b0001);
    queue_request(OP_ADD16, 16'h0FFF, 16'hF001, 3'd0, 4'b1000);
    queue_request(OP_INC16, 16'hFFFF, 16'h0000, 3'd0, 4'b1111);
    queue_request(OP_DEC16, 16'h0000, 16'h0000, 3'd0, 4'b0000);
    queue_request(OP_UNUSED_LAST, 16'hFFFF, 16'hFFFF, 3'd7, 4'b1111);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      a = pick_operand();
      b = pick_operand();
      flags = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) begin
        // BCD arithmetic followed by its decimal adjust
        op = OP_ADD + 5'($urandom_range(0, 3));
        a[7:0] = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        b[7:0] = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        queue_request(op, a, b, 3'($urandom_range(0, 7)), flags, i == 0);
        probe = '0;
        probe.op = op;
        probe.a = a;
        probe.b = b;
        probe.c = flags[0];
        sum = compute_alu_result(probe);
        queue_request(OP_DAA, sum.value, b, 3'($urandom_range(0, 7)),
                      {sum.z, sum.n, sum.h, sum.c});
        i++;
      end else begin
        if ($urandom_range(0, 59) == 0)
          op = 5'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        else
          op = 5'($urandom_range(OP_ADD, OP_DEC16));
        queue_request(op, a, b, 3'($urandom_range(0, 7)), flags,
                      i == 0 || i == 600 || i == 1200);
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (accepted != total_requests || expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
